// File: sv/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants of the transparent run decoder: beat payloads,
// decoder phases, register map and the constant row-step divider.
// ----------------------------------------------------------------------------
`default_nettype none

package trd_pkg;

  // destination line pitch, in pixels
  localparam int unsigned LINE_PITCH = 320;
  localparam int unsigned HALF_PITCH = LINE_PITCH / 2;

  // pen registers wrap at 16 bits
  localparam int unsigned PEN_W = 16;
  localparam logic [PEN_W-1:0] PITCH_PEN = PEN_W'(LINE_PITCH);

  // rows = ceil((skip - half) / pitch) = (skip + bias) / pitch
  localparam int unsigned SKIP_BIAS = LINE_PITCH - 1 - HALF_PITCH;

  // divide by pitch as a multiply by a rounded-up reciprocal,
  // exact for any dividend below 2**DIV_IN_W
  localparam int unsigned DIV_IN_W  = 17;
  localparam int unsigned DIV_SHIFT = DIV_IN_W + $clog2(LINE_PITCH);
  localparam int unsigned RECIP_W   = DIV_IN_W + 1;
  localparam int unsigned PROD_W    = DIV_IN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(LINE_PITCH) - 64'd1) / 64'(LINE_PITCH));

  // window limits are capped so every pixel fits the 11-bit outputs
  localparam int unsigned LIMIT_W = 12;
  localparam logic [LIMIT_W-1:0] OUT_LIMIT = 12'd2048;

  // register map, word index
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_ORIGIN_X      = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y      = 2'd1;
  localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd2;
  localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SKIP_HI = 3'd1,
    PH_NEXT_LO = 3'd2,
    PH_NEXT_HI = 3'd3,
    PH_CNT_LO  = 3'd4,
    PH_CNT_HI  = 3'd5,
    PH_COLOR   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       start_of_image;
    logic       end_of_stream;
  } trd_in_t;

  typedef struct packed {
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [7:0]  pixel_color;
  } trd_out_t;

endpackage

`default_nettype wire

// File: sv/trd_out_buf.sv
// ----------------------------------------------------------------------------
// trd_out_buf
// Two-entry output buffer: an output register plus a skid register, so the
// decoder keeps taking bytes while one pixel waits on a stalled sink.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire trd_pkg::trd_out_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output trd_pkg::trd_out_t      out_data
);
  import trd_pkg::*;

  logic     skid_valid;
  trd_out_t skid_data;
  logic     pop;

  assign pop  = out_valid && out_ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: sv/transparent_run_decoder.sv
// ----------------------------------------------------------------------------
// transparent_run_decoder
// Decodes a skip/draw transparency byte stream into pixel writes, one stream
// byte per beat, at most one pixel per byte.
//
//   channel  signals                               beat
//   in       in_valid, in_ready, in_data            one file byte + flags
//   out      out_valid, out_ready, out_data         one pixel write
//   cfg      psel, penable, pwrite, paddr, pwdata   one register write
//
// One byte is taken every cycle while in_ready is high; a pixel in the window is
// registered into the output buffer when its color byte is taken. The row count
// of a skip word comes from a reciprocal multiply registered from the stored skip
// word, ahead of its use at the count. A stalled sink is absorbed by a two-entry
// output buffer; in_ready drops only when both entries hold pixels.
// Synchronous reset idles the decoder and loads the default window.
// ----------------------------------------------------------------------------
`default_nettype none

module transparent_run_decoder (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire trd_pkg::trd_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output trd_pkg::trd_out_t              out_data,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [trd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import trd_pkg::*;

  // configuration registers
  logic [9:0]  origin_x;
  logic [9:0]  origin_y;
  logic [10:0] window_width;
  logic [10:0] window_height;

  // decoder state
  phase_t           phase, phase_next;
  logic [7:0]       low_byte_hold, low_byte_hold_next;
  logic [PEN_W-1:0] skip_word, skip_word_next;
  logic [PEN_W-1:0] run_left, run_left_next;
  logic [PEN_W-1:0] pen_x, pen_x_next;
  logic [PEN_W-1:0] pen_y, pen_y_next;
  logic [PEN_W-1:0] skip_rows;

  logic             accept;
  logic             cfg_write;
  logic             emit;
  trd_out_t         pixel;
  logic             buf_full;

  logic [PEN_W-1:0] word;
  logic [DIV_IN_W-1:0] div_in;
  logic [PROD_W-1:0]   div_prod;
  logic [PEN_W-1:0] step_back;
  logic [PEN_W-1:0] skip_pen_x;
  logic [PEN_W-1:0] skip_pen_y;
  logic [LIMIT_W-1:0] bottom_sum, bottom;
  logic [LIMIT_W-1:0] right_sum, right;
  logic             row_hit;
  logic             in_window;
  logic [PEN_W-1:0] run_dec;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      window_width  <= 11'd320;
      window_height <= 11'd200;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_ORIGIN_X:      origin_x      <= pwdata[9:0];
        REG_ORIGIN_Y:      origin_y      <= pwdata[9:0];
        REG_WINDOW_WIDTH:  window_width  <= pwdata[10:0];
        REG_WINDOW_HEIGHT: window_height <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ORIGIN_X:      prdata = {22'd0, origin_x};
      REG_ORIGIN_Y:      prdata = {22'd0, origin_y};
      REG_WINDOW_WIDTH:  prdata = {21'd0, window_width};
      REG_WINDOW_HEIGHT: prdata = {21'd0, window_height};
      default:           prdata = '0;
    endcase
  end

  // ------------------------------------------------------------- row step
  // rows = 0 when the skip fits in half a line
  assign div_in   = DIV_IN_W'(skip_word) + DIV_IN_W'(SKIP_BIAS);
  assign div_prod = PROD_W'(div_in) * PROD_W'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (skip_word > PEN_W'(HALF_PITCH)) begin
      skip_rows <= PEN_W'(div_prod >> DIV_SHIFT);
    end else begin
      skip_rows <= '0;
    end
  end

  assign step_back  = skip_rows * PITCH_PEN;
  assign skip_pen_x = pen_x + skip_word - step_back;
  assign skip_pen_y = pen_y + skip_rows;

  assign bottom_sum = LIMIT_W'(origin_y) + LIMIT_W'(window_height);
  assign bottom     = (bottom_sum > OUT_LIMIT) ? OUT_LIMIT : bottom_sum;
  assign row_hit    = skip_pen_y >= PEN_W'(bottom);

  assign right_sum  = LIMIT_W'(origin_x) + LIMIT_W'(window_width);
  assign right      = (right_sum > OUT_LIMIT) ? OUT_LIMIT : right_sum;
  assign in_window  = (pen_x >= PEN_W'(origin_x)) && (pen_x < PEN_W'(right));

  assign word    = {in_data.stream_byte, low_byte_hold};
  assign run_dec = run_left - PEN_W'(1);
  assign accept  = in_valid && in_ready;
  assign in_ready = !buf_full;

  // ----------------------------------------------------------- next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (in_data.end_of_stream) begin
        phase_next = PH_IDLE;
      end else if (in_data.start_of_image) begin
        phase_next = PH_SKIP_HI;
      end else begin
        case (phase)
          PH_IDLE:    phase_next = PH_IDLE;
          PH_SKIP_HI: phase_next = PH_CNT_LO;
          PH_NEXT_LO: phase_next = PH_NEXT_HI;
          PH_NEXT_HI: phase_next = (word == '0) ? PH_IDLE : PH_CNT_LO;
          PH_CNT_LO:  phase_next = PH_CNT_HI;
          PH_CNT_HI:  phase_next = (word == '0 || row_hit) ? PH_IDLE : PH_COLOR;
          PH_COLOR:   phase_next = (run_dec == '0) ? PH_NEXT_LO : PH_COLOR;
          default:    phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // ------------------------------------------------------------- datapath
  always_comb begin
    low_byte_hold_next = low_byte_hold;
    skip_word_next     = skip_word;
    run_left_next      = run_left;
    pen_x_next         = pen_x;
    pen_y_next         = pen_y;
    emit               = 1'b0;
    if (accept && !in_data.end_of_stream) begin
      if (in_data.start_of_image) begin
        pen_x_next         = PEN_W'(origin_x);
        pen_y_next         = PEN_W'(origin_y);
        low_byte_hold_next = in_data.stream_byte;
      end else begin
        case (phase)
          PH_SKIP_HI: skip_word_next = word;
          PH_NEXT_LO: low_byte_hold_next = in_data.stream_byte;
          PH_NEXT_HI: begin
            if (word != '0) begin
              skip_word_next = word;
            end
          end
          PH_CNT_LO:  low_byte_hold_next = in_data.stream_byte;
          PH_CNT_HI: begin
            if (word != '0) begin
              pen_x_next    = skip_pen_x;
              pen_y_next    = skip_pen_y;
              run_left_next = word;
            end
          end
          PH_COLOR: begin
            emit          = in_window;
            pen_x_next    = pen_x + PEN_W'(1);
            run_left_next = run_dec;
          end
          default: ;
        endcase
      end
    end
  end

  assign pixel.pixel_x     = pen_x[10:0];
  assign pixel.pixel_y     = pen_y[10:0];
  assign pixel.pixel_color = in_data.stream_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      low_byte_hold <= '0;
      skip_word     <= '0;
      run_left      <= '0;
      pen_x         <= '0;
      pen_y         <= '0;
    end else begin
      phase         <= phase_next;
      low_byte_hold <= low_byte_hold_next;
      skip_word     <= skip_word_next;
      run_left      <= run_left_next;
      pen_x         <= pen_x_next;
      pen_y         <= pen_y_next;
    end
  end

  trd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (pixel),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // ----------------------------------------------------------- assertions
  a_stall_holds_pixel: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pixel pending");

  a_emit_in_color: assert property (@(posedge clk) disable iff (rst)
    emit |-> (accept && phase == PH_COLOR))
    else $error("pixel produced outside a color run");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_COLOR) |-> (run_left != '0))
    else $error("color phase with empty run");

  a_eos_idles: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.end_of_stream) |=> (phase == PH_IDLE))
    else $error("end of stream did not stop decoding");

endmodule

`default_nettype wire
